### rtl/bsle_pkg.sv
// ----------------------------------------------------------------------------
// bsle_pkg: shared types for the bounded sorted list engine
// Operation and status codes, beat payload structs and the control bundle
// that the controller broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bsle_pkg;

  // Operation codes carried by an input beat
  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_ORDERED = 3'd1,
    OP_DEL_POS = 3'd2,
    OP_DEL_VAL = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;

  // Input beat
  typedef struct packed {
    logic [2:0]               operation;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } in_t;

  // Result beat
  typedef struct packed {
    logic signed [ValueW-1:0] read_data;
    status_e                  status;
    logic [CountW-1:0]        entry_count;
  } out_t;

  // Controller to cell broadcast
  typedef struct packed {
    logic cmp_en;   // latch per-cell compare against the incoming beat
    logic cmp_ord;  // compare is "entry >= value" (else equality)
    logic by_pos;   // target is given by position, not by compare hits
    logic ord;      // ordered insert: empty cells count as hits
    logic ins;      // shift up and drop value at the target
    logic del;      // shift down from the target
    logic load;     // commit the shift this cycle
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/bsle_cell.sv
// ----------------------------------------------------------------------------
// bsle_cell: one list slot
// Holds one entry, latches its own compare result, extends the target chain
// from its left neighbor and shifts in from a neighbor on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module bsle_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned PW  = 7,
  parameter int unsigned CW  = 7
) (
  input  wire logic                                clk_i,
  input  wire bsle_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic signed [bsle_pkg::ValueW-1:0]  cmp_value_i,
  input  wire logic signed [bsle_pkg::ValueW-1:0]  ins_value_i,
  input  wire logic [PW-1:0]                       pos_i,
  input  wire logic [CW-1:0]                       count_i,
  input  wire logic signed [bsle_pkg::ValueW-1:0]  left_entry_i,
  input  wire logic signed [bsle_pkg::ValueW-1:0]  right_entry_i,
  input  wire logic                                ge_i,
  input  wire logic signed [bsle_pkg::ValueW-1:0]  rd_i,
  output logic signed [bsle_pkg::ValueW-1:0]       entry_o,
  output logic                                     ge_o,
  output logic signed [bsle_pkg::ValueW-1:0]       rd_o
);

  logic signed [bsle_pkg::ValueW-1:0] entry_q, entry_d;
  logic                               hit_q, hit_d;
  logic                               valid;
  logic                               own;
  logic                               sel;

  // Slot holds a live entry when it sits below the count
  assign valid = PW'(Idx) < PW'(count_i);

  // Compare latched in the accept cycle
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      if (ctrl_i.cmp_ord) begin
        hit_d = valid & (entry_q >= cmp_value_i);
      end else begin
        hit_d = valid & (entry_q == cmp_value_i);
      end
    end
  end

  // Target chain: set from the first targeted slot onward
  assign own  = ctrl_i.by_pos ? (PW'(Idx) >= pos_i) : (hit_q | (ctrl_i.ord & ~valid));
  assign ge_o = ge_i | own;

  // Shift network
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      if (ctrl_i.ins) begin
        if (ge_i) begin
          entry_d = left_entry_i;
        end else if (ge_o) begin
          entry_d = ins_value_i;
        end
      end else if (ctrl_i.del && ge_o) begin
        entry_d = right_entry_i;
      end
    end
  end

  // Read path: the addressed slot joins the OR chain
  assign sel  = PW'(Idx) == pos_i;
  assign rd_o = rd_i | (sel ? entry_q : '0);

  assign entry_o = entry_q;

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

endmodule

`default_nettype wire

### rtl/bsle_ctrl.sv
// ----------------------------------------------------------------------------
// bsle_ctrl: operation sequencer
// Takes an input beat, drives the cell row in the execute state, keeps the
// entry count and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bsle_ctrl #(
  parameter int unsigned ListDepth = 64,
  parameter int unsigned PW        = 7,
  parameter int unsigned CW        = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire bsle_pkg::in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output bsle_pkg::out_t                           out_data_o,
  input  wire logic                                found_i,
  input  wire logic signed [bsle_pkg::ValueW-1:0]  rd_i,
  output bsle_pkg::cell_ctrl_t                     ctrl_o,
  output logic signed [bsle_pkg::ValueW-1:0]       value_o,
  output logic [PW-1:0]                            pos_o,
  output logic [CW-1:0]                            count_o
);

  bsle_pkg::state_e                   state_q, state_d;
  bsle_pkg::op_e                      op_q;
  logic signed [bsle_pkg::ValueW-1:0] value_q;
  logic [bsle_pkg::PosW-1:0]          pos_q;
  logic [CW-1:0]                      count_q, count_d;
  logic                               out_valid_q;
  bsle_pkg::out_t                     out_q;

  logic                               accept;
  logic                               fire;
  logic                               full;
  logic [PW-1:0]                      pos_x;
  logic [PW-1:0]                      cnt_x;
  logic                               ins, del, by_pos;
  bsle_pkg::status_e                  status;
  logic signed [bsle_pkg::ValueW-1:0] rdata;

  assign accept = in_valid_i & in_ready_o;
  assign fire   = (state_q == bsle_pkg::S_EXEC) & (~out_valid_q | out_ready_i);
  assign pos_x  = PW'(pos_q);
  assign cnt_x  = PW'(count_q);
  assign full   = count_q == CW'(ListDepth);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsle_pkg::S_IDLE: if (accept) state_d = bsle_pkg::S_EXEC;
      bsle_pkg::S_EXEC: if (fire) state_d = bsle_pkg::S_IDLE;
      default: state_d = bsle_pkg::S_IDLE;
    endcase
  end

  // Outputs: decode, status and next count
  always_comb begin
    in_ready_o = state_q == bsle_pkg::S_IDLE;
    status     = bsle_pkg::STAT_OK;
    count_d    = count_q;
    rdata      = '0;
    ins        = 1'b0;
    del        = 1'b0;
    by_pos     = 1'b0;
    unique case (op_q)
      bsle_pkg::OP_INSERT: begin
        by_pos = 1'b1;
        if (pos_x > cnt_x) begin
          status = bsle_pkg::STAT_RANGE;
        end else if (full) begin
          status = bsle_pkg::STAT_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      bsle_pkg::OP_ORDERED: begin
        if (full) begin
          status = bsle_pkg::STAT_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      bsle_pkg::OP_DEL_POS: begin
        by_pos = 1'b1;
        if (pos_x >= cnt_x) begin
          status = bsle_pkg::STAT_RANGE;
        end else begin
          del     = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      bsle_pkg::OP_DEL_VAL: begin
        if (!found_i) begin
          status = bsle_pkg::STAT_NOT_FOUND;
        end else begin
          del     = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      bsle_pkg::OP_READ: begin
        if (pos_x >= cnt_x) begin
          status = bsle_pkg::STAT_RANGE;
        end else begin
          rdata = rd_i;
        end
      end
      default: ;
    endcase

    ctrl_o.cmp_en  = accept;
    ctrl_o.cmp_ord = bsle_pkg::op_e'(in_data_i.operation) == bsle_pkg::OP_ORDERED;
    ctrl_o.by_pos  = by_pos;
    ctrl_o.ord     = op_q == bsle_pkg::OP_ORDERED;
    ctrl_o.ins     = ins;
    ctrl_o.del     = del;
    ctrl_o.load    = fire & (ins | del);
  end

  assign value_o     = value_q;
  assign pos_o       = pos_x;
  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsle_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Beat and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= bsle_pkg::op_e'(in_data_i.operation);
      value_q <= in_data_i.value;
      pos_q   <= in_data_i.position;
    end
    if (fire) begin
      out_q.read_data   <= rdata;
      out_q.status      <= status;
      out_q.entry_count <= bsle_pkg::CountW'(count_d);
    end
  end

endmodule

`default_nettype wire

### rtl/bounded_sorted_list_engine_core.sv
// Timing: the accept cycle latches the per-cell compares; the execute state
// then resolves the target along the cell chain, shifts and registers the
// result beat. A new beat is taken only once the last one leaves execute.
// A stalled result beat holds the execute state.
// Reset: entry count clears to zero; the entry cells are not cleared.
// ----------------------------------------------------------------------------
// bounded_sorted_list_engine_core: bounded ordered list engine
// Row of ListDepth cells with a controller; insert, ordered insert, delete
// by position or value, and read, each giving one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_sorted_list_engine_core #(
  parameter int unsigned ListDepth = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire bsle_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output bsle_pkg::out_t       out_data_o
);

  localparam int unsigned CW = $clog2(ListDepth + 1);
  localparam int unsigned PW = (CW > bsle_pkg::PosW) ? CW : bsle_pkg::PosW;

  bsle_pkg::cell_ctrl_t               ctrl;
  logic signed [bsle_pkg::ValueW-1:0] value;
  logic [PW-1:0]                      pos;
  logic [CW-1:0]                      count;
  logic signed [bsle_pkg::ValueW-1:0] entry [ListDepth];
  logic                               ge    [ListDepth+1];
  logic signed [bsle_pkg::ValueW-1:0] rd    [ListDepth+1];

  // Sequencer
  bsle_ctrl #(
    .ListDepth (ListDepth),
    .PW        (PW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .found_i     (ge[ListDepth]),
    .rd_i        (rd[ListDepth]),
    .ctrl_o      (ctrl),
    .value_o     (value),
    .pos_o       (pos),
    .count_o     (count)
  );

  assign ge[0] = 1'b0;
  assign rd[0] = '0;

  // Cell row
  for (genvar i = 0; i < ListDepth; i++) begin : g_cell
    bsle_cell #(
      .Idx (i),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .cmp_value_i   (in_data_i.value),
      .ins_value_i   (value),
      .pos_i         (pos),
      .count_i       (count),
      .left_entry_i  (entry[(i == 0) ? 0 : i - 1]),
      .right_entry_i (entry[(i == ListDepth - 1) ? i : i + 1]),
      .ge_i          (ge[i]),
      .rd_i          (rd[i]),
      .entry_o       (entry[i]),
      .ge_o          (ge[i+1]),
      .rd_o          (rd[i+1])
    );
  end

`ifndef SYNTHESIS
  // Count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) count <= CW'(ListDepth))
    else $error("entry count above depth");

  // An accepted beat is followed by an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted beat did not enter execute");

  // Count moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count + CW'(1) == $past(count)))
    else $error("entry count jumped");

  // A full status reports a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == bsle_pkg::STAT_FULL) |->
    (out_data_o.entry_count == bsle_pkg::CountW'(ListDepth)))
    else $error("full status with store not full");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_bounded_sorted_list_engine_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_sorted_list_engine_core: self-checking bench for the list engine
// Drives operation beats through the input handshake and checks each result
// beat against a shadow copy of the list kept in the bench. Covers range,
// full-store, not-found and unknown-operation cases, a fill-and-drain pass,
// and a long random run with idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_sorted_list_engine_core;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned RANDOM_OPS   = 1700;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT     = 34;

  // Operation codes with no defined meaning
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  // Values that push the signed compare to its ends
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_NEG = 32'hFFFF_FFFF;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  bsle_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  bsle_pkg::out_t out_data_o;

  // Shadow of the list contents and its length
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int unsigned        shadow_len = 0;

  bsle_pkg::out_t pending_results [$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count    = 0;
  bit             steady         = 1'b0;  // no idling on either side while set

  bounded_sorted_list_engine_core #(
    .ListDepth(LIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow list upkeep
  // ---------------------------------------------------------------------------
  function automatic void shadow_open(int unsigned at, logic signed [31:0] v);
    for (int unsigned i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[at] = v;
    shadow_len++;
  endfunction

  function automatic void shadow_close(int unsigned at);
    for (int unsigned i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
  endfunction

  // Result of one operation beat; updates the shadow list as a side effect
  function automatic bsle_pkg::out_t predict_result(bsle_pkg::in_t item);
    bsle_pkg::out_t res;
    int unsigned    hit;
    int unsigned    pos;
    res        = '0;
    res.status = bsle_pkg::STAT_OK;
    hit        = 0;
    pos        = 32'(item.position);
    case (item.operation)
      bsle_pkg::OP_INSERT: begin
        if (pos > shadow_len) res.status = bsle_pkg::STAT_RANGE;
        else if (shadow_len >= LIST_DEPTH) res.status = bsle_pkg::STAT_FULL;
        else shadow_open(pos, item.value);
      end
      bsle_pkg::OP_ORDERED: begin
        if (shadow_len >= LIST_DEPTH) begin
          res.status = bsle_pkg::STAT_FULL;
        end else begin
          while (hit < shadow_len && $signed(shadow_list[hit]) < $signed(item.value)) hit++;
          shadow_open(hit, item.value);
        end
      end
      bsle_pkg::OP_DEL_POS: begin
        if (pos >= shadow_len) res.status = bsle_pkg::STAT_RANGE;
        else shadow_close(pos);
      end
      bsle_pkg::OP_DEL_VAL: begin
        while (hit < shadow_len && shadow_list[hit] != item.value) hit++;
        if (hit >= shadow_len) res.status = bsle_pkg::STAT_NOT_FOUND;
        else shadow_close(hit);
      end
      bsle_pkg::OP_READ: begin
        if (pos >= shadow_len) res.status = bsle_pkg::STAT_RANGE;
        else res.read_data = shadow_list[pos];
      end
      default: ;  // unknown codes leave everything alone
    endcase
    res.entry_count = shadow_len[6:0];
    return res;
  endfunction

  function automatic bsle_pkg::in_t make_op(logic [2:0] op, logic [31:0] v,
                                            int unsigned pos);
    bsle_pkg::in_t item;
    item.operation = op;
    item.value     = v;
    item.position  = pos[5:0];
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one beat per call, random idle cycles ahead of it
  // ---------------------------------------------------------------------------
  task automatic send_op(input bsle_pkg::in_t item);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_result(item));
  endtask

  // Hold off the input until every pending result beat is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    bsle_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: data %0d status %0d",
                                  out_data_o.read_data, out_data_o.status));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %0d, want %0d",
                                    out_data_o.read_data, want.read_data));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_data_o.status, want.status));
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d",
                                    out_data_o.entry_count, want.entry_count));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mix of extremes, a narrow band that forces duplicates, and full range
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) begin
      case ($urandom_range(3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_NEG;
        default: return 32'd0;
      endcase
    end
    if (roll < 60) return $urandom_range(16) - 8;
    return $urandom;
  endfunction

  // Mostly a position that fits the list, sometimes anywhere
  function automatic int unsigned pick_position();
    int unsigned top;
    top = (shadow_len > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : shadow_len;
    if ($urandom_range(99) < 80) return $urandom_range(top);
    return $urandom_range(LIST_DEPTH - 1);
  endfunction

  // Delete by value: usually an entry that is present
  function automatic logic [31:0] pick_victim();
    if (shadow_len != 0 && $urandom_range(99) < 70)
      return shadow_list[$urandom_range(shadow_len - 1)];
    return pick_value();
  endfunction

  function automatic bsle_pkg::in_t random_op(bit grow);
    int unsigned roll;
    roll = $urandom_range(99);
    // grow phases favor inserts, shrink phases favor deletes
    if (roll < 3)
      return make_op(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), $urandom,
                     $urandom_range(63));
    if (roll < (grow ? 45 : 15))
      return make_op(bsle_pkg::OP_INSERT, pick_value(), pick_position());
    if (roll < (grow ? 80 : 28))
      return make_op(bsle_pkg::OP_ORDERED, pick_value(), pick_position());
    if (roll < (grow ? 86 : 58))
      return make_op(bsle_pkg::OP_DEL_POS, pick_value(), pick_position());
    if (roll < (grow ? 92 : 86))
      return make_op(bsle_pkg::OP_DEL_VAL, pick_victim(), pick_position());
    return make_op(bsle_pkg::OP_READ, pick_value(), pick_position());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Edge cases on an empty and a short list
  task automatic test_directed();
    send_op(make_op(bsle_pkg::OP_READ,    VAL_NEG, 0));    // read on empty list
    send_op(make_op(bsle_pkg::OP_DEL_POS, 32'd0,   0));    // delete on empty list
    send_op(make_op(bsle_pkg::OP_DEL_VAL, 32'd5,   0));    // no match on empty list
    send_op(make_op(bsle_pkg::OP_INSERT,  32'd7,   1));    // insert past the end
    send_op(make_op(bsle_pkg::OP_INSERT,  VAL_MAX, 0));
    send_op(make_op(bsle_pkg::OP_ORDERED, VAL_MIN, 63));   // position ignored
    send_op(make_op(bsle_pkg::OP_ORDERED, 32'd0,   0));
    send_op(make_op(bsle_pkg::OP_ORDERED, 32'd0,   0));    // duplicate goes first
    send_op(make_op(bsle_pkg::OP_INSERT,  VAL_NEG, 4));    // append at the end
    send_op(make_op(bsle_pkg::OP_INSERT,  32'd9,   6));    // past the end again
    send_op(make_op(bsle_pkg::OP_READ,    32'd0,   0));
    send_op(make_op(bsle_pkg::OP_READ,    32'd0,   4));
    send_op(make_op(bsle_pkg::OP_READ,    32'd0,   5));    // one past the end
    send_op(make_op(bsle_pkg::OP_READ,    32'd0,   63));
    send_op(make_op(bsle_pkg::OP_DEL_VAL, 32'd0,   0));
    send_op(make_op(bsle_pkg::OP_DEL_VAL, 32'd42,  0));    // value not present
    send_op(make_op(OP_SPARE_LO,          VAL_NEG, 63));   // unknown codes
    send_op(make_op(OP_SPARE_MID,         32'd0,   0));
    send_op(make_op(OP_SPARE_HI,          VAL_MIN, 21));
    send_op(make_op(bsle_pkg::OP_DEL_POS, 32'd0,   3));    // last entry
    send_op(make_op(bsle_pkg::OP_DEL_POS, 32'd0,   3));    // now out of range
    send_op(make_op(bsle_pkg::OP_DEL_POS, 32'd0,   0));
    send_op(make_op(bsle_pkg::OP_READ,    32'd0,   0));
  endtask

  // Fill to the limit, hit the full-store cases, then empty the list
  task automatic test_full_store();
    while (shadow_len < LIST_DEPTH)
      send_op(make_op(bsle_pkg::OP_ORDERED, pick_value(), 0));
    send_op(make_op(bsle_pkg::OP_INSERT,  32'd1,   0));
    send_op(make_op(bsle_pkg::OP_INSERT,  32'd1,   63));
    send_op(make_op(bsle_pkg::OP_ORDERED, VAL_MIN, 0));
    send_op(make_op(bsle_pkg::OP_READ,    32'd0,   63));
    send_op(make_op(bsle_pkg::OP_DEL_POS, 32'd0,   63));
    send_op(make_op(bsle_pkg::OP_INSERT,  VAL_MAX, 63));   // append into the freed slot
    send_op(make_op(bsle_pkg::OP_READ,    32'd0,   63));
    wait_drained();
    while (shadow_len > 0) begin
      if ($urandom_range(1))
        send_op(make_op(bsle_pkg::OP_DEL_POS, 32'd0, $urandom_range(shadow_len - 1)));
      else
        send_op(make_op(bsle_pkg::OP_DEL_VAL, pick_victim(), 0));
    end
  endtask

  // Long random run in alternating grow and shrink phases
  task automatic test_random_ops();
    bit grow;
    grow = 1'b1;
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      if (n % 150 == 0) grow = ~grow | (shadow_len < 8);
      steady = (n >= 700 && n < 1000);
      if (n == RANDOM_OPS / 2) wait_drained();
      send_op(random_op(grow));
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    test_random_ops();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/bsle_pkg.sv
rtl/bsle_cell.sv
rtl/bsle_ctrl.sv
rtl/bounded_sorted_list_engine_core.sv
tb/sv/tb_bounded_sorted_list_engine_core.sv
